@@ rtl/gfm_pkg.sv @@
// ---------------------------------------------------------------------------
// gfm_pkg: shared types and constants for the GF(2^255-19) field multiplier.
// Holds the request and result structs, the fold factor and the prime limbs.
// ---------------------------------------------------------------------------
`default_nettype none
package gfm_pkg;
	localparam int LimbW = 64;
	localparam int NumLimbs = 4;

	// Fold factor: 2^256 = 38 mod p.
	localparam logic [5:0] FOLD_FACTOR = 6'd38;
	localparam logic [255:0] PRIME = {64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
		64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFED};

	typedef struct packed {
		logic [63:0] b_limb3;
		logic [63:0] b_limb2;
		logic [63:0] b_limb1;
		logic [63:0] b_limb0;
		logic [63:0] a_limb3;
		logic [63:0] a_limb2;
		logic [63:0] a_limb1;
		logic [63:0] a_limb0;
	} gfm_req_t;

	typedef struct packed {
		logic [63:0] prod_limb3;
		logic [63:0] prod_limb2;
		logic [63:0] prod_limb1;
		logic [63:0] prod_limb0;
	} gfm_res_t;
endpackage
`default_nettype wire

@@ rtl/gfm_limb_mul.sv @@
// ---------------------------------------------------------------------------
// gfm_limb_mul: registered 64x64 limb product built from four 32x32 parts.
// Stage one registers the partial products; stage two sums them to 128 bits.
// ---------------------------------------------------------------------------
`default_nettype none
module gfm_limb_mul (
	input  wire logic         clk,
	input  wire logic [63:0]  x,
	input  wire logic [63:0]  y,
	output logic      [127:0] p
);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;

	// Partial products, one 32x32 multiplier each.
	always_ff @(posedge clk) begin
		p00_s1 <= 64'(x[31:0]) * 64'(y[31:0]);
		p01_s1 <= 64'(x[31:0]) * 64'(y[63:32]);
		p10_s1 <= 64'(x[63:32]) * 64'(y[31:0]);
		p11_s1 <= 64'(x[63:32]) * 64'(y[63:32]);
	end

	// Recombine into the full product.
	always_ff @(posedge clk) begin
		p <= {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
			+ {p11_s1, 64'd0};
	end
endmodule
`default_nettype wire

@@ rtl/gf25519_field_multiply.sv @@
// ---------------------------------------------------------------------------
// gf25519_field_multiply: pipelined multiplier for GF(2^255-19).
// Full 512-bit product, two folds by 38, one conditional subtraction of p.
// ---------------------------------------------------------------------------
//  channel   | signals                  | handshake
//  request   | start, busy, req         | taken when start is high, busy low
//  result    | done, res                | shown one cycle, marked by done
//
// One request may enter each cycle; busy is always low. Each result passes
// the partial-product and recombine registers of the limb multipliers, column
// sums, full product, first fold, second fold, trial subtraction and select.
// Reset clears only the valid bits of the pipeline; data registers are free.
// The receiver cannot stall, so nothing is held back.
`default_nettype none
module gf25519_field_multiply (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire gfm_pkg::gfm_req_t req,
	output logic                   done,
	output gfm_pkg::gfm_res_t      res
);
	import gfm_pkg::*;

	localparam int Depth = 8;
	localparam int NumDiag = 2 * NumLimbs - 1;

	logic [Depth-1:0] vld_q;
	logic [63:0] a [NumLimbs];
	logic [63:0] b [NumLimbs];
	logic [127:0] pp [NumLimbs][NumLimbs];
	logic [129:0] diag_s3 [NumDiag];
	logic [511:0] full_s4;
	logic [264:0] r1_s5;
	logic [255:0] r2_s6;
	logic [255:0] r_s7, d_s7;
	logic         nb_s7;

	assign busy = 1'b0;
	assign a = '{req.a_limb0, req.a_limb1, req.a_limb2, req.a_limb3};
	assign b = '{req.b_limb0, req.b_limb1, req.b_limb2, req.b_limb3};

	// Sixteen limb products.
	for (genvar i = 0; i < NumLimbs; i++) begin : g_row
		for (genvar j = 0; j < NumLimbs; j++) begin : g_col
			gfm_limb_mul u_mul (.clk(clk), .x(a[i]), .y(b[j]), .p(pp[i][j]));
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Depth-2:0], start};
		end
	end

	// Column summation, part one: add the limb products of each diagonal.
	always_ff @(posedge clk) begin
		logic [129:0] dsum [NumDiag];
		for (int k = 0; k < NumDiag; k++)
			dsum[k] = '0;
		for (int i = 0; i < NumLimbs; i++) begin
			for (int j = 0; j < NumLimbs; j++) begin
				dsum[i + j] = dsum[i + j] + 130'(pp[i][j]);
			end
		end
		for (int k = 0; k < NumDiag; k++)
			diag_s3[k] <= dsum[k];
	end

	// Column summation, part two: shift the diagonals into the 512-bit product.
	always_ff @(posedge clk) begin
		logic [511:0] acc;
		acc = '0;
		for (int k = 0; k < NumDiag; k++)
			acc = acc + (512'(diag_s3[k]) << (64 * k));
		full_s4 <= acc;
	end

	// First fold: low half plus 38 times the upper half, with 38 = 32 + 4 + 2.
	always_ff @(posedge clk) begin
		r1_s5 <= 265'(full_s4[255:0]) + (265'(full_s4[511:256]) << 5)
			+ (265'(full_s4[511:256]) << 2) + (265'(full_s4[511:256]) << 1);
	end

	// Second fold; carry out of the top limb is dropped.
	always_ff @(posedge clk) begin
		r2_s6 <= r1_s5[255:0] + 256'(r1_s5[264:256] * 15'(FOLD_FACTOR));
	end

	// Trial subtraction of p.
	always_ff @(posedge clk) begin
		logic [256:0] t;
		t = {1'b0, r2_s6} - {1'b0, PRIME};
		r_s7 <= r2_s6;
		d_s7 <= t[255:0];
		nb_s7 <= ~t[256];
	end

	// Select and register the result.
	always_ff @(posedge clk) begin
		logic [255:0] v;
		v = nb_s7 ? d_s7 : r_s7;
		res <= '{prod_limb3: v[255:192], prod_limb2: v[191:128],
			prod_limb1: v[127:64], prod_limb0: v[63:0]};
	end

	assign done = vld_q[Depth-1];
endmodule
`default_nettype wire

@@ rtl/gfm_checker.sv @@
// ---------------------------------------------------------------------------
// gfm_checker: port-level checks for the field multiplier.
// Confirms fixed latency and that the block never refuses a request.
// ---------------------------------------------------------------------------
`default_nettype none
module gfm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	// The block never pushes back on requests.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// A request always yields a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##8 done) else $error("missing result");

	// No result without a matching earlier request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 8)) else $error("spurious result");
endmodule

bind gf25519_field_multiply gfm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
`default_nettype wire

@@ tb/gf25519_field_multiply_tb.sv @@
// ---------------------------------------------------------------------------
// gf25519_field_multiply_tb: self-checking bench for the field multiplier.
// Drives operand pairs through the request port, predicts each reduced
// product with a wide-vector model and checks every result in order.
// ---------------------------------------------------------------------------
`default_nettype none

// Scoreboard: predicts the product of each request and checks results in order.
class gfm_product_board;
	gfm_pkg::gfm_res_t pending_products[$];
	int mismatches;
	int strays;

	// Work out the reduced product the way the block does.
	function gfm_pkg::gfm_res_t reduce_product(gfm_pkg::gfm_req_t rq);
		logic [255:0] a_val;
		logic [255:0] b_val;
		logic [511:0] full;
		logic [263:0] fold1;
		logic [263:0] fold2;
		logic [255:0] low;
		logic [256:0] diff;
		gfm_pkg::gfm_res_t r;
		a_val = {rq.a_limb3, rq.a_limb2, rq.a_limb1, rq.a_limb0};
		b_val = {rq.b_limb3, rq.b_limb2, rq.b_limb1, rq.b_limb0};
		full = {256'd0, a_val} * {256'd0, b_val};
		// First fold: low half plus 38 times the high half.
		fold1 = {8'd0, full[255:0]} + 264'd38 * {8'd0, full[511:256]};
		// Second fold of the carry; a carry out of the top is dropped.
		fold2 = {8'd0, fold1[255:0]} + 264'd38 * {256'd0, fold1[263:256]};
		low = fold2[255:0];
		// Subtract p once when no borrow results.
		diff = {1'b0, low} - {1'b0, gfm_pkg::PRIME};
		r = diff[256] ? low : diff[255:0];
		return r;
	endfunction

	function void note_request(gfm_pkg::gfm_req_t rq);
		pending_products.push_back(reduce_product(rq));
	endfunction

	function void check_result(gfm_pkg::gfm_res_t got);
		gfm_pkg::gfm_res_t want;
		if (pending_products.size() == 0) begin
			strays++;
			if (mismatches + strays <= 10)
				$display("ERROR: result with no request pending: %h", got);
			return;
		end
		want = pending_products.pop_front();
		if (got != want) begin
			mismatches++;
			if (mismatches + strays <= 10)
				$display("ERROR: product mismatch\n  expected %h_%h_%h_%h\n  actual   %h_%h_%h_%h",
					want.prod_limb3, want.prod_limb2, want.prod_limb1, want.prod_limb0,
					got.prod_limb3, got.prod_limb2, got.prod_limb1, got.prod_limb0);
		end
	endfunction
endclass

module gf25519_field_multiply_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 8;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	gfm_pkg::gfm_req_t req;
	logic done;
	gfm_pkg::gfm_res_t res;

	int idle_pct;
	gfm_product_board board;

	gf25519_field_multiply u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		#2ms;
		$display("FAIL gf25519_field_multiply");
		$finish;
	end

	// Check each result at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(res);
	end

	function automatic logic [63:0] pick_limb();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: v = 64'hFFFFFFFFFFFFFFED;
			3: v = 64'h7FFFFFFFFFFFFFFF;
			4: v = 64'd1 << $urandom_range(0, 63);
			5: v = 64'd38;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// Send one request, holding start until it is taken; idle beforehand.
	task automatic send_request(gfm_pkg::gfm_req_t rq);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(rq);
	endtask

	// Wait for every expected product to arrive.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_products.size() != 0)
			@(posedge clk);
	endtask

	function automatic gfm_pkg::gfm_req_t pack_operands(logic [255:0] a, logic [255:0] b);
		gfm_pkg::gfm_req_t rq;
		rq = {b, a};
		return rq;
	endfunction

	initial begin
		logic [255:0] edge_vals[8];
		gfm_pkg::gfm_req_t rq;
		int n;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, one, p-1, p, p+1, 2^255, all ones and 19.
		edge_vals[0] = '0;
		edge_vals[1] = 256'd1;
		edge_vals[2] = gfm_pkg::PRIME - 256'd1;
		edge_vals[3] = gfm_pkg::PRIME;
		edge_vals[4] = gfm_pkg::PRIME + 256'd1;
		edge_vals[5] = 256'd1 << 255;
		edge_vals[6] = '1;
		edge_vals[7] = 256'd19;
		for (int i = 0; i < 8; i++)
			send_request(pack_operands(edge_vals[i], edge_vals[i]));
		for (int i = 0; i < 8; i++)
			send_request(pack_operands(edge_vals[i], edge_vals[(i + 3) % 8]));
		send_request(pack_operands('1, 256'd2));
		send_request(pack_operands(gfm_pkg::PRIME - 256'd1, 256'd2));
		// Pause until every product is back.
		drain();

		// Random: three idling phases.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
			n = 600;
			for (int k = 0; k < n; k++) begin
				rq.a_limb0 = pick_limb();
				rq.a_limb1 = pick_limb();
				rq.a_limb2 = pick_limb();
				rq.a_limb3 = pick_limb();
				rq.b_limb0 = pick_limb();
				rq.b_limb1 = pick_limb();
				rq.b_limb2 = pick_limb();
				rq.b_limb3 = pick_limb();
				send_request(rq);
			end
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (board.mismatches == 0 && board.strays == 0 &&
				board.pending_products.size() == 0)
			$display("PASS gf25519_field_multiply");
		else
			$display("FAIL gf25519_field_multiply");
		$finish;
	end
endmodule

`default_nettype wire
